### rtl/cptw_pkg.sv
`timescale 1ns / 1ps
package cptw_pkg;

  localparam int CoordDimDefault = 3;
  localparam int CoordW = 32;
  localparam int DiffW = 33;
  localparam int DotW = 68;
  localparam int VolW = 138;
  localparam int NumW = 170;
  localparam int QuotW = NumW;
  localparam int WeightW = 32;

  localparam logic [2:0] RegionA = 3'd0;
  localparam logic [2:0] RegionB = 3'd1;
  localparam logic [2:0] RegionAb = 3'd2;
  localparam logic [2:0] RegionC = 3'd3;
  localparam logic [2:0] RegionAc = 3'd4;
  localparam logic [2:0] RegionBc = 3'd5;
  localparam logic [2:0] RegionInside = 3'd6;
  localparam logic [2:0] RegionFallback = 3'd7;

  // Saturate a wide signed value into a 32-bit weight.
  function automatic logic signed [WeightW-1:0] clamp_weight(input logic signed [NumW:0] v);
    logic signed [NumW:0] hi;
    logic signed [NumW:0] lo;
    hi = (NumW+1)'(32'sh7fffffff);
    lo = -(NumW+1)'(64'sh80000000);
    if (v > hi) begin
      clamp_weight = 32'sh7fffffff;
    end else if (v < lo) begin
      clamp_weight = 32'sh80000000;
    end else begin
      clamp_weight = v[WeightW-1:0];
    end
  endfunction

endpackage

### rtl/cptw_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, truncating toward zero.
// The numerator is shifted up by 30 before dividing; a zero divisor gives zero.
module cptw_div
  import cptw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [NumW-1:0]  num,
  input  logic signed [NumW-1:0]  den,
  output logic                    out_valid,
  output logic signed [NumW:0]    quot
);

  localparam int MagW = NumW + 30;
  localparam int Steps = MagW;

  logic [Steps:0]           vld;
  logic [MagW-1:0]          n_mag [Steps+1];
  logic [NumW-1:0]          d_mag [Steps+1];
  logic [NumW:0]            rem   [Steps+1];
  logic [Steps:0]           neg;
  logic [Steps:0]           dz;

  always_comb begin
    logic signed [MagW-1:0] ns;
    ns = {num, 30'd0};
    n_mag[0] = ns[MagW-1] ? MagW'(-ns) : MagW'(ns);
    d_mag[0] = den[NumW-1] ? NumW'(-den) : NumW'(den);
    rem[0] = '0;
    neg[0] = ns[MagW-1] ^ den[NumW-1];
    dz[0] = (den == '0);
    vld[0] = in_valid;
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    always_ff @(posedge clk) begin
      logic [NumW:0] r2;
      r2 = {rem[s][NumW-1:0], n_mag[s][MagW-1]};
      if (r2 >= {1'b0, d_mag[s]}) begin
        rem[s+1] <= r2 - {1'b0, d_mag[s]};
        n_mag[s+1] <= {n_mag[s][MagW-2:0], 1'b1};
      end else begin
        rem[s+1] <= r2;
        n_mag[s+1] <= {n_mag[s][MagW-2:0], 1'b0};
      end
      d_mag[s+1] <= d_mag[s];
      neg[s+1] <= neg[s];
      dz[s+1] <= dz[s];
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end
  end

  // The quotient magnitude ends up in n_mag; its low NumW+1 bits suffice after clamping
  // only if the top is zero, so saturate the magnitude into NumW+1 signed bits.
  always_ff @(posedge clk) begin
    logic [MagW-1:0] qm;
    logic [NumW:0]   qs;
    qm = n_mag[Steps];
    if (qm[MagW-1:NumW] != '0) begin
      qs = {1'b0, {NumW{1'b1}}};
    end else begin
      qs = {1'b0, qm[NumW-1:0]};
    end
    if (dz[Steps]) begin
      quot <= '0;
    end else begin
      quot <= neg[Steps] ? -$signed(qs) : $signed(qs);
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[Steps];
    end
  end

endmodule

### rtl/closest_point_triangle_weights.sv
`timescale 1ns / 1ps
// Channel   Ports                                      Handshake
// request   p_*, a_*, b_*, c_* (Q16.16)                start high, busy low
// result    weight_a/b/c (Q2.30), region               done high for one cycle
//
// One request enters per cycle; busy is tied low because nothing stalls.
// A request passes through seven geometry stages, the divider pipeline and the
// output stage before done rises. The divider, one quotient bit per stage, is the
// deepest part of the pipeline.
// Synchronous reset clears only the valid bits; data registers carry no reset.
// The receiver cannot stall, so results leave the pipeline as they arrive.
module closest_point_triangle_weights
  import cptw_pkg::*;
#(
  parameter int COORD_DIM = CoordDimDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [CoordW-1:0]  p_x,
  input  logic signed [CoordW-1:0]  p_y,
  input  logic signed [CoordW-1:0]  p_z,
  input  logic signed [CoordW-1:0]  a_x,
  input  logic signed [CoordW-1:0]  a_y,
  input  logic signed [CoordW-1:0]  a_z,
  input  logic signed [CoordW-1:0]  b_x,
  input  logic signed [CoordW-1:0]  b_y,
  input  logic signed [CoordW-1:0]  b_z,
  input  logic signed [CoordW-1:0]  c_x,
  input  logic signed [CoordW-1:0]  c_y,
  input  logic signed [CoordW-1:0]  c_z,
  output logic                      done,
  output logic signed [WeightW-1:0] weight_a,
  output logic signed [WeightW-1:0] weight_b,
  output logic signed [WeightW-1:0] weight_c,
  output logic [2:0]                region
);

  localparam int HalfW = DotW / 2;

  assign busy = 1'b0;

  // Stage 1: edge and offset vectors.
  logic v1;
  logic signed [DiffW-1:0] e0 [3], e1 [3], pa [3], pb [3], pc [3];

  always_ff @(posedge clk) begin
    logic signed [CoordW-1:0] p [3], a [3], b [3], c [3];
    p[0] = p_x; p[1] = p_y; p[2] = (COORD_DIM > 2) ? p_z : '0;
    a[0] = a_x; a[1] = a_y; a[2] = (COORD_DIM > 2) ? a_z : '0;
    b[0] = b_x; b[1] = b_y; b[2] = (COORD_DIM > 2) ? b_z : '0;
    c[0] = c_x; c[1] = c_y; c[2] = (COORD_DIM > 2) ? c_z : '0;
    for (int k = 0; k < 3; k++) begin
      e0[k] <= DiffW'(b[k]) - DiffW'(a[k]);
      e1[k] <= DiffW'(c[k]) - DiffW'(a[k]);
      pa[k] <= DiffW'(p[k]) - DiffW'(a[k]);
      pb[k] <= DiffW'(p[k]) - DiffW'(b[k]);
      pc[k] <= DiffW'(p[k]) - DiffW'(c[k]);
    end
    v1 <= rst ? 1'b0 : start;
  end

  // Stage 2: per-axis products.
  logic v2;
  logic signed [2*DiffW-1:0] m [6][3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      m[0][k] <= pa[k] * e0[k];
      m[1][k] <= pa[k] * e1[k];
      m[2][k] <= pb[k] * e0[k];
      m[3][k] <= pb[k] * e1[k];
      m[4][k] <= pc[k] * e0[k];
      m[5][k] <= pc[k] * e1[k];
    end
    v2 <= rst ? 1'b0 : v1;
  end

  // Stage 3: dot products.
  logic v3;
  logic signed [DotW-1:0] d [6];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 6; j++) begin
      d[j] <= DotW'(m[j][0]) + DotW'(m[j][1]) + DotW'(m[j][2]);
    end
    v3 <= rst ? 1'b0 : v2;
  end

  // Stage 4: partial products of the cross terms. Each dot product is split into
  // a signed upper half and an unsigned lower half so no multiplier exceeds 35 bits.
  logic v4;
  logic signed [DotW-1:0] d20, d21, d30, d31, d40, d41;
  logic signed [2*HalfW-1:0] pp_hh [6];
  logic signed [2*HalfW+1:0] pp_hl [6], pp_lh [6];
  logic [2*HalfW-1:0]        pp_ll [6];

  always_ff @(posedge clk) begin
    logic signed [DotW-1:0] u [6], w [6];
    u[0] = d[0]; w[0] = d[3];
    u[1] = d[2]; w[1] = d[1];
    u[2] = d[4]; w[2] = d[1];
    u[3] = d[0]; w[3] = d[5];
    u[4] = d[2]; w[4] = d[5];
    u[5] = d[4]; w[5] = d[3];
    for (int j = 0; j < 6; j++) begin
      pp_hh[j] <= $signed(u[j][DotW-1:HalfW]) * $signed(w[j][DotW-1:HalfW]);
      pp_hl[j] <= $signed(u[j][DotW-1:HalfW]) * $signed({1'b0, w[j][HalfW-1:0]});
      pp_lh[j] <= $signed({1'b0, u[j][HalfW-1:0]}) * $signed(w[j][DotW-1:HalfW]);
      pp_ll[j] <= u[j][HalfW-1:0] * w[j][HalfW-1:0];
    end
    d20 <= d[0]; d21 <= d[1]; d30 <= d[2];
    d31 <= d[3]; d40 <= d[4]; d41 <= d[5];
    v4 <= rst ? 1'b0 : v3;
  end

  // Stage 5: the partial products are weighted and summed into full cross terms.
  logic v5;
  logic signed [2*DotW-1:0] x [6];
  logic signed [DotW-1:0] t20, t21, t30, t31, t40, t41;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 6; j++) begin
      x[j] <= ((2*DotW)'(pp_hh[j]) << (2*HalfW)) + ((2*DotW)'(pp_hl[j]) << HalfW)
            + ((2*DotW)'(pp_lh[j]) << HalfW) + (2*DotW)'(pp_ll[j]);
    end
    t20 <= d20; t21 <= d21; t30 <= d30; t31 <= d31; t40 <= d40; t41 <= d41;
    v5 <= rst ? 1'b0 : v4;
  end

  // Stage 6: sub-volumes.
  logic v6;
  logic signed [VolW-1:0] va, vb, vc;
  logic signed [DotW-1:0] s20, s21, s30, s31, s40, s41;

  always_ff @(posedge clk) begin
    vc <= VolW'(x[0]) - VolW'(x[1]);
    vb <= VolW'(x[2]) - VolW'(x[3]);
    va <= VolW'(x[4]) - VolW'(x[5]);
    s20 <= t20; s21 <= t21; s30 <= t30; s31 <= t31; s40 <= t40; s41 <= t41;
    v6 <= rst ? 1'b0 : v5;
  end

  // Stage 7: region decision, in the fixed priority order.
  logic v7;
  logic [2:0] reg7;
  logic signed [NumW-1:0] n7 [3];
  logic signed [NumW-1:0] den7;

  always_ff @(posedge clk) begin
    logic signed [DotW:0] d310, d410, diff0, diff1;
    logic signed [VolW:0] tot;
    d310 = (DotW+1)'(s31) - (DotW+1)'(s30);
    d410 = (DotW+1)'(s41) - (DotW+1)'(s40);
    diff0 = (DotW+1)'(s20) - (DotW+1)'(s30);
    diff1 = (DotW+1)'(s21) - (DotW+1)'(s41);
    tot = (VolW+1)'(va) + (VolW+1)'(vb) + (VolW+1)'(vc);
    n7[0] <= '0; n7[1] <= '0; n7[2] <= '0; den7 <= '0;
    if (s20 <= 0 && s21 <= 0) begin
      reg7 <= RegionA;
    end else if (s30 >= 0 && s31 <= s30) begin
      reg7 <= RegionB;
    end else if (vc < 0 && s20 >= 0 && s30 <= 0) begin
      reg7 <= RegionAb;
      n7[0] <= NumW'(s20); den7 <= NumW'(diff0);
    end else if (s41 >= 0 && s40 <= s41) begin
      reg7 <= RegionC;
    end else if (vb < 0 && s21 >= 0 && s41 <= 0) begin
      reg7 <= RegionAc;
      n7[0] <= NumW'(s21); den7 <= NumW'(diff1);
    end else if (va < 0 && d310 >= 0 && d410 <= 0) begin
      reg7 <= RegionBc;
      n7[0] <= NumW'(d310); den7 <= NumW'(d310 - d410);
    end else if (tot > 0) begin
      reg7 <= RegionInside;
      n7[0] <= NumW'(va); n7[1] <= NumW'(vb); n7[2] <= NumW'(vc);
      den7 <= NumW'(tot);
    end else begin
      // The fallback edge is flagged through the second numerator: 1 for AB, 2 for AC.
      reg7 <= RegionFallback;
      if (diff0 > diff1) begin
        n7[0] <= NumW'(s20); den7 <= NumW'(diff0); n7[2] <= '0;
        n7[1] <= NumW'(1);
      end else begin
        n7[0] <= NumW'(s21); den7 <= NumW'(diff1);
        n7[1] <= NumW'(2);
      end
    end
    v7 <= rst ? 1'b0 : v6;
  end

  // Three dividers in lockstep; side data travels in a matching delay line.
  localparam int DivLat = NumW + 31;
  logic dv [3];
  logic signed [NumW:0] q [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    cptw_div u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v7),
      .num       (n7[i]),
      .den       (den7),
      .out_valid (dv[i]),
      .quot      (q[i])
    );
  end

  logic [2:0] reg_dl  [DivLat];
  logic [1:0] sel_dl  [DivLat];

  always_ff @(posedge clk) begin
    reg_dl[0] <= reg7;
    sel_dl[0] <= n7[1][1:0];
    for (int s = 1; s < DivLat; s++) begin
      reg_dl[s] <= reg_dl[s-1];
      sel_dl[s] <= sel_dl[s-1];
    end
  end

  // Output stage: build the three weights from the quotients.
  always_ff @(posedge clk) begin
    logic [2:0] rg;
    logic signed [NumW:0] one, qq, om;
    logic signed [NumW:0] wa, wb, wc;
    rg = reg_dl[DivLat-1];
    one = (NumW+1)'(64'sd1073741824);
    qq = q[0];
    om = one - qq;
    wa = '0; wb = '0; wc = '0;
    unique case (rg)
      RegionA: wa = one;
      RegionB: wb = one;
      RegionC: wc = one;
      RegionAb: begin wa = om; wb = qq; end
      RegionAc: begin wa = om; wc = qq; end
      RegionBc: begin wb = om; wc = qq; end
      RegionInside: begin wa = q[0]; wb = q[1]; wc = q[2]; end
      RegionFallback: begin
        wa = om;
        if (sel_dl[DivLat-1] == 2'd1) begin
          wb = qq;
        end else begin
          wc = qq;
        end
      end
      default: wa = '0;
    endcase
    weight_a <= clamp_weight(wa);
    weight_b <= clamp_weight(wb);
    weight_c <= clamp_weight(wc);
    region <= rg;
    done <= rst ? 1'b0 : dv[0];
  end

  // The three dividers run in lockstep.
  assert property (@(posedge clk) disable iff (rst) dv[0] == dv[1] && dv[1] == dv[2])
    else $error("divider lanes out of step");

  // Vertex region A gives exactly one full weight.
  assert property (@(posedge clk) disable iff (rst)
    done && region == RegionA |-> weight_a == 32'sh40000000 && weight_b == 0 && weight_c == 0)
    else $error("vertex A weights wrong");

  // The interface never stalls.
  assert property (@(posedge clk) !busy)
    else $error("busy raised");

endmodule

### tb/closest_point_triangle_weights_check.sv
`timescale 1ns / 1ps
module closest_point_triangle_weights_check
  import cptw_pkg::*;
#(
  parameter int COORD_DIM = CoordDimDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic signed [CoordW-1:0]  p_x,
  input  logic signed [CoordW-1:0]  p_y,
  input  logic signed [CoordW-1:0]  p_z,
  input  logic signed [CoordW-1:0]  a_x,
  input  logic signed [CoordW-1:0]  a_y,
  input  logic signed [CoordW-1:0]  a_z,
  input  logic signed [CoordW-1:0]  b_x,
  input  logic signed [CoordW-1:0]  b_y,
  input  logic signed [CoordW-1:0]  b_z,
  input  logic signed [CoordW-1:0]  c_x,
  input  logic signed [CoordW-1:0]  c_y,
  input  logic signed [CoordW-1:0]  c_z,
  input  logic                      done,
  input  logic signed [WeightW-1:0] weight_a,
  input  logic signed [WeightW-1:0] weight_b,
  input  logic signed [WeightW-1:0] weight_c,
  input  logic [2:0]                region,
  output int                        errors,
  output int                        pending
);

  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic signed [WeightW-1:0] wa;
    logic signed [WeightW-1:0] wb;
    logic signed [WeightW-1:0] wc;
    logic [2:0]                zone;
  } weights_t;

  weights_t weights_due[$];

  localparam wide_t UnitWeight = wide_t'(1) <<< 30;

  function automatic wide_t dot3(input wide_t u[3], input wide_t v[3]);
    wide_t acc;
    acc = '0;
    for (int k = 0; k < COORD_DIM && k < 3; k++) acc += u[k] * v[k];
    return acc;
  endfunction

  // Truncated (num * 2^30) / den; a zero divisor yields zero.
  function automatic wide_t frac30(input wide_t num, input wide_t den);
    if (den == 0) return '0;
    return (num <<< 30) / den;
  endfunction

  function automatic logic signed [WeightW-1:0] sat32(input wide_t v);
    if (v > wide_t'(64'sh7fffffff)) return 32'sh7fffffff;
    if (v < -wide_t'(64'sh80000000)) return 32'sh80000000;
    return v[WeightW-1:0];
  endfunction

  function automatic weights_t pack_weights(input wide_t wa, input wide_t wb, input wide_t wc,
                                            input logic [2:0] zone);
    weights_t r;
    r.wa = sat32(wa);
    r.wb = sat32(wb);
    r.wc = sat32(wc);
    r.zone = zone;
    return r;
  endfunction

  function automatic weights_t closest_weights(input logic signed [31:0] pt[3],
                                               input logic signed [31:0] ca[3],
                                               input logic signed [31:0] cb[3],
                                               input logic signed [31:0] cc[3]);
    wide_t e0[3], e1[3], pa[3], pb[3], pc[3];
    wide_t d20, d21, d30, d31, d40, d41, va, vb, vc, d310, d410, tot, q, diff0, diff1;
    for (int k = 0; k < 3; k++) begin
      e0[k] = wide_t'(cb[k]) - wide_t'(ca[k]);
      e1[k] = wide_t'(cc[k]) - wide_t'(ca[k]);
      pa[k] = wide_t'(pt[k]) - wide_t'(ca[k]);
      pb[k] = wide_t'(pt[k]) - wide_t'(cb[k]);
      pc[k] = wide_t'(pt[k]) - wide_t'(cc[k]);
    end
    d20 = dot3(pa, e0);
    d21 = dot3(pa, e1);
    if (d20 <= 0 && d21 <= 0) return pack_weights(UnitWeight, 0, 0, RegionA);
    d30 = dot3(pb, e0);
    d31 = dot3(pb, e1);
    if (d30 >= 0 && d31 <= d30) return pack_weights(0, UnitWeight, 0, RegionB);
    vc = d20 * d31 - d30 * d21;
    if (vc < 0 && d20 >= 0 && d30 <= 0) begin
      q = frac30(d20, d20 - d30);
      return pack_weights(UnitWeight - q, q, 0, RegionAb);
    end
    d40 = dot3(pc, e0);
    d41 = dot3(pc, e1);
    if (d41 >= 0 && d40 <= d41) return pack_weights(0, 0, UnitWeight, RegionC);
    vb = d40 * d21 - d20 * d41;
    if (vb < 0 && d21 >= 0 && d41 <= 0) begin
      q = frac30(d21, d21 - d41);
      return pack_weights(UnitWeight - q, 0, q, RegionAc);
    end
    va = d30 * d41 - d40 * d31;
    d310 = d31 - d30;
    d410 = d41 - d40;
    if (va < 0 && d310 >= 0 && d410 <= 0) begin
      q = frac30(d310, d310 - d410);
      return pack_weights(0, UnitWeight - q, q, RegionBc);
    end
    tot = va + vb + vc;
    if (tot > 0)
      return pack_weights(frac30(va, tot), frac30(vb, tot), frac30(vc, tot), RegionInside);
    // Degenerate triangle: project onto whichever of AB or AC wins the comparison.
    diff0 = d20 - d30;
    diff1 = d21 - d41;
    if (diff0 > diff1) begin
      q = frac30(d20, diff0);
      return pack_weights(UnitWeight - q, q, 0, RegionFallback);
    end
    q = frac30(d21, diff1);
    return pack_weights(UnitWeight - q, 0, q, RegionFallback);
  endfunction

  always @(posedge clk) begin
    logic signed [31:0] pt[3], ca[3], cb[3], cc[3];
    weights_t want, got;
    if (rst) begin
      errors <= 0;
      pending <= 0;
    end else begin
      if (start && !busy) begin
        pt = '{p_x, p_y, p_z};
        ca = '{a_x, a_y, a_z};
        cb = '{b_x, b_y, b_z};
        cc = '{c_x, c_y, c_z};
        weights_due.push_back(closest_weights(pt, ca, cb, cc));
      end
      if (done) begin
        got = '{weight_a, weight_b, weight_c, region};
        if (weights_due.size() == 0) begin
          if (errors < 10) $display("unexpected result %h", got);
          errors <= errors + 1;
        end else begin
          want = weights_due.pop_front();
          if (want != got) begin
            if (errors < 10)
              $display("mismatch: exp wa=%h wb=%h wc=%h region=%0d, got wa=%h wb=%h wc=%h region=%0d",
                       want.wa, want.wb, want.wc, want.zone, got.wa, got.wb, got.wc, got.zone);
            errors <= errors + 1;
          end
        end
      end
      pending <= weights_due.size();
    end
  end

endmodule

### tb/closest_point_triangle_weights_test.sv
`timescale 1ns / 1ps
module closest_point_triangle_weights_test;
  import cptw_pkg::*;

  // The pipeline is seven geometry stages plus one divider stage per
  // quotient bit; the drain allowance DrainCycles covers its whole depth.
  localparam int DrainCycles = 300;
  localparam int CycleLimit = 400000;
  localparam int ItemsPerPhase = 500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [CoordW-1:0] p_x = '0, p_y = '0, p_z = '0;
  logic signed [CoordW-1:0] a_x = '0, a_y = '0, a_z = '0;
  logic signed [CoordW-1:0] b_x = '0, b_y = '0, b_z = '0;
  logic signed [CoordW-1:0] c_x = '0, c_y = '0, c_z = '0;
  logic done;
  logic signed [WeightW-1:0] weight_a, weight_b, weight_c;
  logic [2:0] region;
  int errors, pending;
  int cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  closest_point_triangle_weights dut (.*);
  closest_point_triangle_weights_check checker_i (.*);

  // A hung pipeline must not stall the run forever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one request at the current rising edge and hold it until an edge
  // accepts it. busy is checked at the falling edge, away from any update.
  task automatic issue(input logic signed [31:0] pt[3], input logic signed [31:0] ca[3],
                       input logic signed [31:0] cb[3], input logic signed [31:0] cc[3]);
    start <= 1'b1;
    p_x <= pt[0]; p_y <= pt[1]; p_z <= pt[2];
    a_x <= ca[0]; a_y <= ca[1]; a_z <= ca[2];
    b_x <= cb[0]; b_y <= cb[1]; b_z <= cb[2];
    c_x <= cc[0]; c_y <= cc[1]; c_z <= cc[2];
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Idle the request side by repeated idle cycles, each taken with the given percent
  // chance, so that about that share of all cycles is idle.
  task automatic maybe_idle(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Points on a coarse integer grid land exactly on vertices and edges often.
  function automatic logic signed [31:0] grid_coord();
    return ($signed($urandom_range(16)) - 8) <<< 16;
  endfunction

  function automatic logic signed [31:0] near_coord();
    return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  task automatic random_request();
    logic signed [31:0] pt[3], ca[3], cb[3], cc[3];
    int kind;
    int m;
    kind = $urandom_range(9);
    m = $signed($urandom_range(6)) - 3;
    for (int k = 0; k < 3; k++) begin
      case (kind)
        0, 1: begin
          // Full-range coordinates exercise every bit and the saturation paths.
          pt[k] = $urandom; ca[k] = $urandom; cb[k] = $urandom; cc[k] = $urandom;
        end
        2, 3, 4: begin
          pt[k] = grid_coord(); ca[k] = grid_coord(); cb[k] = grid_coord();
          cc[k] = grid_coord();
        end
        5: begin
          // Collinear or coincident corners can reach the degenerate fallback.
          pt[k] = grid_coord(); ca[k] = grid_coord(); cb[k] = grid_coord();
          cc[k] = ca[k] + m * (cb[k] - ca[k]);
        end
        default: begin
          pt[k] = near_coord(); ca[k] = near_coord(); cb[k] = near_coord();
          cc[k] = near_coord();
        end
      endcase
    end
    issue(pt, ca, cb, cc);
  endtask

  task automatic directed_requests();
    logic signed [31:0] mx, mn;
    logic signed [31:0] o[3], ux[3], uy[3], uxy[3], ctr[3], far[3];
    logic signed [31:0] hi3[3], lo3[3], mix[3];
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    o = '{0, 0, 0};
    ux = '{32'sh0001_0000, 0, 0};
    uy = '{0, 32'sh0001_0000, 0};
    uxy = '{32'sh0001_0000, 32'sh0001_0000, 0};
    ctr = '{32'sh0000_4000, 32'sh0000_4000, 32'sh0000_8000};
    far = '{32'sh0003_0000, 32'sh0003_0000, 0};
    hi3 = '{mx, mx, mx};
    lo3 = '{mn, mn, mn};
    mix = '{mx, mn, mx};
    issue('{-32'sh1_0000, -32'sh1_0000, 0}, o, ux, uy);        // vertex A
    issue('{32'sh2_0000, -32'sh1_0000, 0}, o, ux, uy);         // vertex B
    issue('{32'sh0_8000, -32'sh1_0000, 0}, o, ux, uy);         // edge AB
    issue('{-32'sh1_0000, 32'sh2_0000, 0}, o, ux, uy);         // vertex C
    issue('{-32'sh1_0000, 32'sh0_8000, 0}, o, ux, uy);         // edge AC
    issue(far, o, ux, uy);                                     // edge BC
    issue(ctr, o, ux, uy);                                     // interior
    issue(ctr, ux, ux, ux);                                    // coincident corners
    issue(ctr, o, ux, '{32'sh2_0000, 0, 0});                   // collinear corners
    issue(uxy, o, ux, uy);
    issue(o, o, o, o);
    issue(hi3, lo3, hi3, mix);
    issue(lo3, hi3, lo3, mix);
    issue(mix, lo3, hi3, '{mn, mx, mn});
    issue(hi3, hi3, hi3, hi3);
    issue(lo3, o, hi3, lo3);
    issue('{mx, mx, mn}, '{mn, 0, 0}, '{mx, 0, 0}, '{0, mx, 0});
    issue('{1, -1, 1}, o, '{1, 0, 0}, '{0, 1, 0});             // tiny triangle
    issue(ctr, o, uy, ux);                                     // reversed winding
  endtask

  initial begin
    int idle_pct[4] = '{0, 81, 0, 32};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    directed_requests();
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < ItemsPerPhase; n++) begin
        maybe_idle(idle_pct[ph]);
        random_request();
      end
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
